/* design/mglm_pkg.sv */
`timescale 1ns / 1ps
// Package for the microphone gain and level meter.
// Field widths, register indexes and reset values; no dependencies.
package mglm_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int LEVEL_W       = 15;
    localparam int GAIN_W        = 16;
    localparam int DECAY_W       = 16;
    localparam int WFRAMES_W     = 8;
    localparam int COUNT_W       = 16;
    localparam int OUT_ENERGY_W  = 48;
    localparam int SQ_W          = 31;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int ENERGY_BITS_DEF    = 48;

    // Register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_DECAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FRAMES = 2'd2;

    localparam logic [GAIN_W-1:0]    GAIN_RESET    = 16'd256;
    localparam logic [DECAY_W-1:0]   DECAY_RESET   = 16'd62915;
    localparam logic [WFRAMES_W-1:0] WFRAMES_RESET = 8'd128;

    localparam logic [LEVEL_W-1:0]  LEVEL_MAX = 15'h7FFF;
    localparam logic [COUNT_W-1:0]  COUNT_MAX = 16'hFFFF;
    // Square reported for a full-scale negative sample
    localparam logic [SQ_W-1:0]     SQ_NEG_FULL = 31'h4000_0000;

endpackage

/* design/mic_gain_level_meter.sv */
`timescale 1ns / 1ps
// Top level of the microphone gain and level meter.
// Depends on mglm_pkg.
//
// Applies a Q(16-GAIN_FRAC_BITS).GAIN_FRAC_BITS gain to each 16-bit sample with
// truncation toward zero and int16 clamping, tracks a per-frame peak that drives
// a fast-rise, exponential-decay level, and reports peak, saturating energy and
// saturating sample count once every window_frames frames. One result word is
// produced per input word. The block takes one word per clock unless a stalled
// output backs up the pipeline; each word passes through the four register
// stages (input register, gain multiply, square, accumulate and output
// register). Stages hold independently, so empty stages fill even while a
// result waits at the output. Configuration writes must be made while idle.
module mic_gain_level_meter #(
    parameter int GAIN_FRAC_BITS = mglm_pkg::GAIN_FRAC_BITS_DEF,
    parameter int ENERGY_BITS    = mglm_pkg::ENERGY_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [mglm_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic [mglm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [mglm_pkg::SAMPLE_W-1:0]  s_sample,
    input  logic                                  s_frame_last,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [mglm_pkg::SAMPLE_W-1:0]  m_scaled_sample,
    output logic [mglm_pkg::LEVEL_W-1:0]          m_level,
    output logic                                  m_window_done,
    output logic [mglm_pkg::LEVEL_W-1:0]          m_window_peak,
    output logic [mglm_pkg::OUT_ENERGY_W-1:0]     m_window_energy,
    output logic [mglm_pkg::COUNT_W-1:0]          m_window_samples
);
    import mglm_pkg::*;

    localparam int MAG_W  = SAMPLE_W + 1;
    localparam int PROD_W = MAG_W + GAIN_W;

    // Configuration registers
    logic [GAIN_W-1:0]    gain_reg;
    logic [DECAY_W-1:0]   decay_reg;
    logic [WFRAMES_W-1:0] wframes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= GAIN_RESET;
            decay_reg   <= DECAY_RESET;
            wframes_reg <= WFRAMES_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_GAIN:          gain_reg    <= cfg_wdata[GAIN_W-1:0];
                CFG_LEVEL_DECAY:   decay_reg   <= cfg_wdata[DECAY_W-1:0];
                CFG_WINDOW_FRAMES: wframes_reg <= cfg_wdata[WFRAMES_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage valids and flow control
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdyo;

    assign rdyo    = !vo_reg || m_ready;
    assign rdy3    = !v3_reg || rdyo;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    logic ld1, ld2, ld3, ldo;
    assign ld1 = s_valid && rdy1;
    assign ld2 = v1_reg && rdy2;
    assign ld3 = v2_reg && rdy3;
    assign ldo = v3_reg && rdyo;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdyo) vo_reg <= v3_reg;
        end
    end

    // Stage 1: input register
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic                       s1_last_reg;

    always_ff @(posedge aclk) begin
        if (ld1) begin
            s1_sample_reg <= s_sample;
            s1_last_reg   <= s_frame_last;
        end
    end

    // Stage 2: gain multiply on magnitude, truncate, clamp
    logic              s1_neg;
    logic [MAG_W-1:0]  s1_mag;
    logic [PROD_W-1:0] s1_prod;
    logic [PROD_W-1:0] s1_shift;
    logic signed [SAMPLE_W-1:0] v_next;
    logic [LEVEL_W-1:0] av_next;
    logic               full_next;

    always_comb begin
        s1_neg   = s1_sample_reg[SAMPLE_W-1];
        s1_mag   = s1_neg ? (~{1'b1, s1_sample_reg} + MAG_W'(1))
                          : {1'b0, s1_sample_reg};
        s1_prod  = PROD_W'(s1_mag) * PROD_W'(gain_reg);
        s1_shift = s1_prod >> GAIN_FRAC_BITS;
        full_next = 1'b0;
        if (s1_neg) begin
            if (s1_shift >= PROD_W'(32768)) begin
                v_next    = {1'b1, {(SAMPLE_W-1){1'b0}}};
                av_next   = LEVEL_MAX;
                full_next = 1'b1;
            end else begin
                v_next  = -$signed(s1_shift[SAMPLE_W-1:0]);
                av_next = s1_shift[LEVEL_W-1:0];
            end
        end else begin
            if (s1_shift >= PROD_W'(32767)) begin
                v_next  = {1'b0, LEVEL_MAX};
                av_next = LEVEL_MAX;
            end else begin
                v_next  = $signed(s1_shift[SAMPLE_W-1:0]);
                av_next = s1_shift[LEVEL_W-1:0];
            end
        end
    end

    logic signed [SAMPLE_W-1:0] s2_v_reg;
    logic [LEVEL_W-1:0]         s2_av_reg;
    logic                       s2_full_reg;
    logic                       s2_last_reg;

    always_ff @(posedge aclk) begin
        if (ld2) begin
            s2_v_reg    <= v_next;
            s2_av_reg   <= av_next;
            s2_full_reg <= full_next;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Stage 3: square
    logic [SQ_W-1:0] sq_next;
    assign sq_next = s2_full_reg ? SQ_NEG_FULL
                                 : SQ_W'(SQ_W'(s2_av_reg) * SQ_W'(s2_av_reg));

    logic signed [SAMPLE_W-1:0] s3_v_reg;
    logic [LEVEL_W-1:0]         s3_av_reg;
    logic [SQ_W-1:0]            s3_sq_reg;
    logic                       s3_last_reg;

    always_ff @(posedge aclk) begin
        if (ld3) begin
            s3_v_reg    <= s2_v_reg;
            s3_av_reg   <= s2_av_reg;
            s3_sq_reg   <= sq_next;
            s3_last_reg <= s2_last_reg;
        end
    end

    // Stage 4: accumulators, level and window bookkeeping
    logic [LEVEL_W-1:0]     fpeak_reg, fpeak_next;
    logic [LEVEL_W-1:0]     level_reg, level_next;
    logic [LEVEL_W-1:0]     wpeak_reg, wpeak_next;
    logic [ENERGY_BITS-1:0] energy_reg, energy_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [WFRAMES_W-1:0]   fcount_reg, fcount_next;

    logic [LEVEL_W-1:0]     fpeak_upd, wpeak_upd;
    logic [ENERGY_BITS:0]   esum;
    logic [ENERGY_BITS-1:0] energy_upd;
    logic [COUNT_W-1:0]     count_upd;
    logic [LEVEL_W+DECAY_W-1:0] decay_prod;
    logic [WFRAMES_W-1:0]   fcount_inc;
    logic                   done;

    always_comb begin
        fpeak_upd  = (s3_av_reg > fpeak_reg) ? s3_av_reg : fpeak_reg;
        wpeak_upd  = (s3_av_reg > wpeak_reg) ? s3_av_reg : wpeak_reg;
        esum       = {1'b0, energy_reg} + {{(ENERGY_BITS+1-SQ_W){1'b0}}, s3_sq_reg};
        // saturate on carry out
        energy_upd = esum[ENERGY_BITS] ? {ENERGY_BITS{1'b1}} : esum[ENERGY_BITS-1:0];
        count_upd  = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
        decay_prod = (LEVEL_W+DECAY_W)'(level_reg) * (LEVEL_W+DECAY_W)'(decay_reg);
        fcount_inc = fcount_reg + WFRAMES_W'(1);

        fpeak_next  = fpeak_upd;
        wpeak_next  = wpeak_upd;
        energy_next = energy_upd;
        count_next  = count_upd;
        level_next  = level_reg;
        fcount_next = fcount_reg;
        done        = 1'b0;

        if (s3_last_reg) begin
            // fast rise to the frame peak, else decay
            level_next  = (fpeak_upd > level_reg) ? fpeak_upd
                                                  : decay_prod[LEVEL_W+DECAY_W-1:DECAY_W];
            fpeak_next  = '0;
            fcount_next = fcount_inc;
            if (fcount_inc >= wframes_reg) begin
                done        = 1'b1;
                fcount_next = '0;
                wpeak_next  = '0;
                energy_next = '0;
                count_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fpeak_reg  <= '0;
            level_reg  <= '0;
            wpeak_reg  <= '0;
            energy_reg <= '0;
            count_reg  <= '0;
            fcount_reg <= '0;
        end else if (ldo) begin
            fpeak_reg  <= fpeak_next;
            level_reg  <= level_next;
            wpeak_reg  <= wpeak_next;
            energy_reg <= energy_next;
            count_reg  <= count_next;
            fcount_reg <= fcount_next;
        end
    end

    // Report the low bits of the energy sum, zero-extended when it is narrower
    logic [OUT_ENERGY_W-1:0] energy_rep;
    if (ENERGY_BITS >= OUT_ENERGY_W) begin : g_energy_trunc
        assign energy_rep = energy_upd[OUT_ENERGY_W-1:0];
    end else begin : g_energy_ext
        assign energy_rep = {{(OUT_ENERGY_W-ENERGY_BITS){1'b0}}, energy_upd};
    end

    // Output register
    logic signed [SAMPLE_W-1:0] o_scaled_reg;
    logic [LEVEL_W-1:0]         o_level_reg;
    logic                       o_done_reg;
    logic [LEVEL_W-1:0]         o_wpeak_reg;
    logic [OUT_ENERGY_W-1:0]    o_energy_reg;
    logic [COUNT_W-1:0]         o_count_reg;

    always_ff @(posedge aclk) begin
        if (ldo) begin
            o_scaled_reg <= s3_v_reg;
            o_level_reg  <= level_next;
            o_done_reg   <= done;
            o_wpeak_reg  <= done ? wpeak_upd : '0;
            o_energy_reg <= done ? energy_rep : '0;
            o_count_reg  <= done ? count_upd : '0;
        end
    end

    assign m_valid          = vo_reg;
    assign m_scaled_sample  = o_scaled_reg;
    assign m_level          = o_level_reg;
    assign m_window_done    = o_done_reg;
    assign m_window_peak    = o_wpeak_reg;
    assign m_window_energy  = o_energy_reg;
    assign m_window_samples = o_count_reg;

endmodule

/* design/mglm_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the microphone gain and level meter, bound to the top.
// Depends on mglm_pkg.
module mglm_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic signed [mglm_pkg::SAMPLE_W-1:0]  s_sample,
    input logic                                  s_frame_last,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [mglm_pkg::SAMPLE_W-1:0]  m_scaled_sample,
    input logic [mglm_pkg::LEVEL_W-1:0]          m_level,
    input logic                                  m_window_done,
    input logic [mglm_pkg::LEVEL_W-1:0]          m_window_peak,
    input logic [mglm_pkg::OUT_ENERGY_W-1:0]     m_window_energy,
    input logic [mglm_pkg::COUNT_W-1:0]          m_window_samples
);
    import mglm_pkg::*;

    // A waiting input word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_sample) && $stable(s_frame_last))
        else $error("input word changed while waiting");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scaled_sample)
            && $stable(m_level) && $stable(m_window_done)
            && $stable(m_window_energy) && $stable(m_window_samples))
        else $error("result word changed while stalled");

    // Window fields are zero unless a window closes
    a_window_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_window_done |-> m_window_peak == '0
            && m_window_energy == '0 && m_window_samples == '0)
        else $error("window fields set without window close");

    // A closed window always counts at least the closing sample
    a_window_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_window_done |-> m_window_samples != '0)
        else $error("window closed with zero samples");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind mic_gain_level_meter mglm_checker u_mglm_checker (.*);
